// ===== rtl/gmrf_pkg.sv =====
// shared types and constants for the group maximum reject filter
`default_nettype none
package gmrf_pkg;

    localparam int ID_W     = 32;
    localparam int ENERGY_W = 16;
    localparam int INDEX_W  = 31;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [INDEX_W-1:0]  index;
        logic [ENERGY_W-1:0] energy;
    } t_entry;

endpackage
`default_nettype wire

// ===== rtl/gmrf_store.sv =====
// entry buffer: one write port and one registered read port
`default_nettype none
module gmrf_store #(
    parameter int GROUP_DEPTH = 32
) (
    input  wire                               i_clk,
    input  wire                               i_wr_en,
    input  wire  [$clog2(GROUP_DEPTH)-1:0]    i_wr_addr,
    input  wire  gmrf_pkg::t_entry            i_wr_data,
    input  wire                               i_rd_en,
    input  wire  [$clog2(GROUP_DEPTH)-1:0]    i_rd_addr,
    output gmrf_pkg::t_entry                  o_rd_data
);
    import gmrf_pkg::*;

    t_entry r_mem [GROUP_DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// ===== rtl/group_max_reject_filter_unit.sv =====
// top level of the group maximum reject filter
//
// An item is taken when start is high and busy is low. An item that does not
// close a group of two or more stored entries leaves busy low. Closing such a
// group holds busy high through the drain and closing states: the buffer
// memory gives one entry per cycle on its single read port, its read data is
// registered, the drain state ends when it sees the read pipeline empty, and
// a closing state follows. A data item that closed the group is added to the
// new group in that closing state. Each rejected index appears once on the o_
// ports for one cycle with o_strobe high; the receiver cannot stall, so every
// strobed cycle is a transfer. Results of one group come in buffer order; each
// leaves in the cycle after the next reject of the group is found, and the
// last one in the cycle after the closing state.
`default_nettype none
module group_max_reject_filter_unit #(
    parameter int GROUP_DEPTH = 32
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire  [gmrf_pkg::ID_W-1:0]        i_group_id,
    input  wire  [gmrf_pkg::ENERGY_W-1:0]    i_energy,
    input  wire  [gmrf_pkg::INDEX_W-1:0]     i_entry_index,
    input  wire                              i_flush,
    output logic                             o_strobe,
    output logic [gmrf_pkg::INDEX_W-1:0]     o_reject_index,
    output logic                             o_last_of_run,
    output logic                             o_group_overflow
);
    import gmrf_pkg::*;

    localparam int AW    = $clog2(GROUP_DEPTH);
    localparam int CNT_W = $clog2(GROUP_DEPTH + 1);

    t_state              r_state, n_state;
    logic                r_open, n_open;
    logic [ID_W-1:0]     r_open_id, n_open_id;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [ENERGY_W-1:0] r_max, n_max;
    logic                r_ovf, n_ovf;
    logic                r_pend_add, n_pend_add;
    logic [ID_W-1:0]     r_pend_id, n_pend_id;
    logic [ENERGY_W-1:0] r_pend_energy, n_pend_energy;
    logic [INDEX_W-1:0]  r_pend_index, n_pend_index;
    logic [CNT_W-1:0]    r_rd_addr, n_rd_addr;
    logic                r_rd_vld, n_rd_vld;
    logic                r_hold_vld, n_hold_vld;
    logic [INDEX_W-1:0]  r_hold_index, n_hold_index;
    logic                r_strobe, n_strobe;
    logic [INDEX_W-1:0]  r_out_index, n_out_index;
    logic                r_out_last, n_out_last;
    logic                r_out_ovf, n_out_ovf;

    logic                accept;
    logic                close_req;
    logic                drain_req;
    logic                issue;
    logic                reject;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    t_entry              wr_data;
    t_entry              rd_data;

    // entry being added and the group state it is added to
    logic                add_en;
    logic [ID_W-1:0]     add_id;
    logic [ENERGY_W-1:0] add_energy;
    logic [INDEX_W-1:0]  add_index;
    logic                base_clear;
    logic [CNT_W-1:0]    base_count;
    logic [ENERGY_W-1:0] base_max;
    logic                base_ovf;
    logic                room;

    assign accept    = start && !busy;
    assign close_req = r_open && (i_flush || (i_group_id != r_open_id));
    assign drain_req = close_req && (r_count > CNT_W'(1));
    assign issue     = (r_state == ST_DRAIN) && (r_rd_addr < r_count);
    assign reject    = r_rd_vld && (rd_data.energy != r_max);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && drain_req) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!issue && !r_rd_vld) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        busy       = 1'b1;
        add_en     = 1'b0;
        base_clear = 1'b0;
        add_id     = r_pend_id;
        add_energy = r_pend_energy;
        add_index  = r_pend_index;
        unique case (r_state)
            ST_IDLE: begin
                busy       = 1'b0;
                add_en     = accept && !drain_req && !i_flush;
                base_clear = accept && !drain_req && (close_req || !r_open);
                add_id     = i_group_id;
                add_energy = i_energy;
                add_index  = i_entry_index;
            end
            ST_DRAIN: begin
                busy = 1'b1;
            end
            ST_FINISH: begin
                add_en     = r_pend_add;
                base_clear = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    always_comb begin
        base_count = base_clear ? '0 : r_count;
        base_max   = base_clear ? '0 : r_max;
        base_ovf   = base_clear ? 1'b0 : r_ovf;
        room       = base_count < CNT_W'(GROUP_DEPTH);
        wr_en      = add_en && room;
        wr_addr    = base_count[AW-1:0];
        wr_data    = '{index: add_index, energy: add_energy};
    end

    // datapath next values
    always_comb begin
        n_open        = r_open;
        n_open_id     = r_open_id;
        n_count       = r_count;
        n_max         = r_max;
        n_ovf         = r_ovf;
        n_pend_add    = r_pend_add;
        n_pend_id     = r_pend_id;
        n_pend_energy = r_pend_energy;
        n_pend_index  = r_pend_index;
        n_rd_addr     = r_rd_addr;
        n_rd_vld      = issue;
        n_hold_vld    = r_hold_vld;
        n_hold_index  = r_hold_index;
        n_strobe      = 1'b0;
        n_out_index   = r_out_index;
        n_out_last    = r_out_last;
        n_out_ovf     = r_out_ovf;

        if (base_clear) begin
            n_open  = 1'b0;
            n_count = '0;
            n_max   = '0;
            n_ovf   = 1'b0;
        end
        if (add_en) begin
            n_open    = 1'b1;
            n_open_id = add_id;
            n_max     = (add_energy > base_max) ? add_energy : base_max;
            n_count   = room ? base_count + CNT_W'(1) : base_count;
            n_ovf     = room ? base_ovf : 1'b1;
        end

        if ((r_state == ST_IDLE) && accept && drain_req) begin
            n_pend_add    = !i_flush;
            n_pend_id     = i_group_id;
            n_pend_energy = i_energy;
            n_pend_index  = i_entry_index;
            n_rd_addr     = '0;
            n_hold_vld    = 1'b0;
        end

        if (issue) begin
            n_rd_addr = r_rd_addr + CNT_W'(1);
        end

        // hold each reject back one step so the final one can carry last
        if (reject) begin
            n_hold_vld   = 1'b1;
            n_hold_index = rd_data.index;
            if (r_hold_vld) begin
                n_strobe    = 1'b1;
                n_out_index = r_hold_index;
                n_out_last  = 1'b0;
                n_out_ovf   = r_ovf;
            end
        end

        if (r_state == ST_FINISH) begin
            n_pend_add = 1'b0;
            n_hold_vld = 1'b0;
            if (r_hold_vld) begin
                n_strobe    = 1'b1;
                n_out_index = r_hold_index;
                n_out_last  = 1'b1;
                n_out_ovf   = r_ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_open     <= 1'b0;
            r_open_id  <= '0;
            r_count    <= '0;
            r_max      <= '0;
            r_ovf      <= 1'b0;
            r_pend_add <= 1'b0;
            r_rd_addr  <= '0;
            r_rd_vld   <= 1'b0;
            r_hold_vld <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_open     <= n_open;
            r_open_id  <= n_open_id;
            r_count    <= n_count;
            r_max      <= n_max;
            r_ovf      <= n_ovf;
            r_pend_add <= n_pend_add;
            r_rd_addr  <= n_rd_addr;
            r_rd_vld   <= n_rd_vld;
            r_hold_vld <= n_hold_vld;
            r_strobe   <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_id     <= n_pend_id;
        r_pend_energy <= n_pend_energy;
        r_pend_index  <= n_pend_index;
        r_hold_index  <= n_hold_index;
        r_out_index   <= n_out_index;
        r_out_last    <= n_out_last;
        r_out_ovf     <= n_out_ovf;
    end

    gmrf_store #(
        .GROUP_DEPTH (GROUP_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (issue),
        .i_rd_addr (r_rd_addr[AW-1:0]),
        .o_rd_data (rd_data)
    );

    assign o_strobe         = r_strobe;
    assign o_reject_index   = r_out_index;
    assign o_last_of_run    = r_out_last;
    assign o_group_overflow = r_out_ovf;

endmodule
`default_nettype wire
